FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the semaphore block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define CSFW_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked on every edge
`define CSFW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Types, codes and defaults of the counting semaphore with waiter queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam int COUNT_W  = 17;
  localparam int CFG_W    = 16;
  localparam int TID_W    = 8;
  localparam int REQ_W    = 2;
  localparam int EV_W     = 3;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WAIT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SIGNAL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  // Result codes
  localparam logic [EV_W-1:0] EV_GRANTED      = 3'd0;
  localparam logic [EV_W-1:0] EV_BLOCKED      = 3'd1;
  localparam logic [EV_W-1:0] EV_WOKEN        = 3'd2;
  localparam logic [EV_W-1:0] EV_NO_WAITER    = 3'd3;
  localparam logic [EV_W-1:0] EV_WOKEN_FAIL   = 3'd4;
  localparam logic [EV_W-1:0] EV_CLOSED_EMPTY = 3'd5;
  localparam logic [EV_W-1:0] EV_QUEUE_FULL   = 3'd6;
  localparam logic [EV_W-1:0] EV_OVERFLOW     = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [TID_W-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic [EV_W-1:0]  event_res;
    logic [TID_W-1:0] thread_out;
    logic             last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted request
    logic step;   // perform one result step of the held request
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             occ_zero;
    logic             occ_one;
    logic             out_free;
  } dp_status_t;

endpackage

FILE: design/counting_semaphore_fifo_waiters_core.sv
// Counting semaphore with a FIFO of waiting threads. Write cfg_initial_value to
// load the count. A request is wait, signal, close or the unused code; wait and
// signal give one result, close one per queued waiter (oldest first, last set
// on the final one) or a single closed-empty result, the unused code none. A
// request is accepted in idle and run in exec, plus flush for a close of more
// than one waiter; the run holds while the result side stalls, else a close
// takes one waiter per cycle, as the queue RAM delivers one entry per cycle.
// Only one request is in work at a time; the next is accepted back in idle.
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core
// Top level: sequencer plus datapath with count, waiter queue and result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module counting_semaphore_fifo_waiters_core #(
  parameter int QUEUE_DEPTH    = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  csfw_pkg::in_item_t         in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output csfw_pkg::out_item_t        out_data,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [csfw_pkg::CFG_W-1:0] cfg_initial_value
);

  csfw_pkg::ctrl_cmd_t  cmd;
  csfw_pkg::dp_status_t status;

  // Sequencer: hold each accepted request until all its results are issued
  csfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: count, queue pointers, waiter RAM and the result register that
  // decouples the result side from the sequencer
  csfw_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_data           (in_data),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_initial_value (cfg_initial_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data)
  );

  // A step never overwrites a result still waiting for transfer
  `CSFW_ASSERT_RST(a_step_needs_room, clk, rst_n, cmd.step |-> status.out_free, "step with full result register")
  // Capture and step never coincide
  `CSFW_ASSERT_RST(a_load_step_excl, clk, rst_n, !(cmd.load && cmd.step), "load and step together")
  // After a request transfer the block is busy with it
  `CSFW_ASSERT_RST(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "accepted while busy")

endmodule

FILE: design/csfw_ram.sv
// ----------------------------------------------------------------------------
// csfw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/csfw_dp.sv
// ----------------------------------------------------------------------------
// csfw_dp
// Semaphore datapath: count, waiter queue pointers, queue RAM, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csfw_dp #(
  parameter int QUEUE_DEPTH    = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  csfw_pkg::ctrl_cmd_t             cmd,
  output csfw_pkg::dp_status_t            status,
  input  csfw_pkg::in_item_t              in_data,
  input  logic                            cfg_wr_en,
  input  logic [csfw_pkg::CFG_W-1:0]      cfg_initial_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output csfw_pkg::out_item_t             out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);
  localparam int CW = csfw_pkg::COUNT_W;
  localparam logic [CW-1:0] COUNT_MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COUNT_MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0]             count_r, count_nxt;
  logic [PTR_W-1:0]                 head_r, head_nxt, head_inc;
  logic [PTR_W-1:0]                 tail_r, tail_nxt, tail_inc;
  logic [OCC_W-1:0]                 occ_r, occ_nxt;
  logic [csfw_pkg::REQ_W-1:0]       req_r;
  logic [THREAD_ID_BITS-1:0]        tid_r;
  logic                             out_valid_r, out_valid_nxt;
  csfw_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                             push, pop, emit;
  logic                             out_free;
  logic                             cnt_pos;
  logic [THREAD_ID_BITS-1:0]        rd_tid;
  logic [PTR_W-1:0]                 rd_addr;
  logic [THREAD_ID_BITS+7:0]        in_tid_wide;
  logic [THREAD_ID_BITS+7:0]        tid_r_wide;
  logic [THREAD_ID_BITS+7:0]        rd_tid_wide;
  logic [csfw_pkg::TID_W-1:0]       tid_r_out;
  logic [csfw_pkg::TID_W-1:0]       rd_tid_out;

  // Convert between the 8-bit port id and the stored id width
  assign in_tid_wide = {{THREAD_ID_BITS{1'b0}}, in_data.thread_id};
  assign tid_r_wide  = {8'h00, tid_r};
  assign rd_tid_wide = {8'h00, rd_tid};
  assign tid_r_out   = tid_r_wide[csfw_pkg::TID_W-1:0];
  assign rd_tid_out  = rd_tid_wide[csfw_pkg::TID_W-1:0];

  assign head_inc = (head_r == LAST_POS) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == LAST_POS) ? '0 : tail_r + PTR_W'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_pos  = !count_r[CW-1] && (count_r != '0);

  always_comb begin
    count_nxt    = count_r;
    push         = 1'b0;
    pop          = 1'b0;
    emit         = 1'b0;
    out_data_nxt = out_data_r;
    if (cmd.step) begin
      unique case (req_r)
        csfw_pkg::REQ_WAIT: begin
          emit = 1'b1;
          out_data_nxt.thread_out = tid_r_out;
          out_data_nxt.last       = 1'b1;
          if (cnt_pos) begin
            count_nxt = count_r - CW'(1);
            out_data_nxt.event_res = csfw_pkg::EV_GRANTED;
          end else if (occ_r >= FULL_OCC || count_r == COUNT_MINV) begin
            out_data_nxt.event_res = csfw_pkg::EV_QUEUE_FULL;
          end else begin
            count_nxt = count_r - CW'(1);
            push      = 1'b1;
            out_data_nxt.event_res = csfw_pkg::EV_BLOCKED;
          end
        end
        csfw_pkg::REQ_SIGNAL: begin
          emit = 1'b1;
          out_data_nxt.last = 1'b1;
          out_data_nxt.thread_out = '0;
          if (count_r == COUNT_MAXV) begin
            out_data_nxt.event_res = csfw_pkg::EV_OVERFLOW;
          end else begin
            count_nxt = count_r + CW'(1);
            // new count at or below zero means the old count was negative
            if (count_r[CW-1] && occ_r != '0) begin
              pop = 1'b1;
              out_data_nxt.event_res  = csfw_pkg::EV_WOKEN;
              out_data_nxt.thread_out = rd_tid_out;
            end else begin
              out_data_nxt.event_res = csfw_pkg::EV_NO_WAITER;
            end
          end
        end
        csfw_pkg::REQ_CLOSE: begin
          emit = 1'b1;
          if (occ_r == '0) begin
            out_data_nxt.event_res  = csfw_pkg::EV_CLOSED_EMPTY;
            out_data_nxt.thread_out = '0;
            out_data_nxt.last       = 1'b1;
          end else begin
            pop = 1'b1;
            out_data_nxt.event_res  = csfw_pkg::EV_WOKEN_FAIL;
            out_data_nxt.thread_out = rd_tid_out;
            out_data_nxt.last       = (occ_r == OCC_W'(1));
          end
        end
        default: begin
          // unused request code: no result
        end
      endcase
    end
    if (cfg_wr_en) begin
      count_nxt = {1'b0, cfg_initial_value};
    end
  end

  always_comb begin
    head_nxt = pop  ? head_inc : head_r;
    tail_nxt = push ? tail_inc : tail_r;
    occ_nxt  = occ_r;
    if (push) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Read ahead so the RAM output shows the current head entry by the time a step needs it
  assign rd_addr = head_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data.req_type;
      tid_r <= in_tid_wide[THREAD_ID_BITS-1:0];
    end
    out_data_r <= out_data_nxt;
  end

  csfw_ram #(
    .WIDTH (THREAD_ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_waiter_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail_r),
    .wr_data (tid_r),
    .rd_addr (rd_addr),
    .rd_data (rd_tid)
  );

  assign status.req      = req_r;
  assign status.occ_zero = (occ_r == '0);
  assign status.occ_one  = (occ_r == OCC_W'(1));
  assign status.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/csfw_ctrl.sv
// ----------------------------------------------------------------------------
// csfw_ctrl
// Sequencer: accept one request, run its result steps, return to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csfw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csfw_pkg::dp_status_t status,
  output csfw_pkg::ctrl_cmd_t  cmd
);

  csfw_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csfw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = csfw_pkg::S_EXEC;
        end
      end
      csfw_pkg::S_EXEC: begin
        if (status.out_free) begin
          if (status.req == csfw_pkg::REQ_CLOSE && !status.occ_zero && !status.occ_one) begin
            state_nxt = csfw_pkg::S_FLUSH;
          end else begin
            state_nxt = csfw_pkg::S_IDLE;
          end
        end
      end
      csfw_pkg::S_FLUSH: begin
        if (status.out_free && status.occ_one) begin
          state_nxt = csfw_pkg::S_IDLE;
        end
      end
      default: state_nxt = csfw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    unique case (state_r) inside
      csfw_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      csfw_pkg::S_EXEC, csfw_pkg::S_FLUSH: begin
        cmd.step = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csfw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the counting semaphore with its queue of waiters.
// A request table covers the edge cases first: reset count, ceiling, empty and
// busy close, unused request code. The waiter queue is then filled to hit the
// full-queue refusal and a flush of every entry. Random phases follow with
// changing start counts and idle patterns on both channels. Every result
// transfer is compared with a predictor that keeps its own count and queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int QDEPTH          = csfw_pkg::QUEUE_DEPTH_DEF;
  localparam int COUNT_W         = csfw_pkg::COUNT_W;
  localparam int CFG_W           = csfw_pkg::CFG_W;
  localparam int TID_W           = csfw_pkg::TID_W;
  localparam int REQ_W           = csfw_pkg::REQ_W;
  localparam int SETTLE_CYCLES   = 6;
  localparam int ITEMS_PER_PHASE = 11;
  localparam int RANDOM_PHASES   = 8;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  localparam logic signed [COUNT_W-1:0] COUNT_FLOOR = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_CEIL  = {1'b0, {(COUNT_W-1){1'b1}}};

  localparam csfw_pkg::in_item_t  NO_REQ   = '0;
  localparam csfw_pkg::out_item_t NO_CHECK = '0;

  // One row of the directed table: either a register write or a request,
  // optionally with the single result written out by hand.
  typedef struct packed {
    logic                is_cfg;
    logic [CFG_W-1:0]    cfg_val;
    csfw_pkg::in_item_t  req;
    logic                typed;
    csfw_pkg::out_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // count 0 after reset
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'h00}, 1'b1,
      '{csfw_pkg::EV_NO_WAITER, 8'h00, 1'b1}},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'hFF}, 1'b1,
      '{csfw_pkg::EV_GRANTED, 8'hFF, 1'b1}},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'h00}, 1'b1,
      '{csfw_pkg::EV_BLOCKED, 8'h00, 1'b1}},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'hA5}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'h00}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_CLOSE, 8'h00}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_CLOSE, 8'hFF}, 1'b1,
      '{csfw_pkg::EV_CLOSED_EMPTY, 8'h00, 1'b1}},
    // count still negative after the flush, queue empty
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'h00}, 1'b1,
      '{csfw_pkg::EV_NO_WAITER, 8'h00, 1'b1}},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_NONE, 8'h5A}, 1'b0, NO_CHECK},
    // ceiling
    '{1'b1, 16'hFFFF, NO_REQ, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'h00}, 1'b1,
      '{csfw_pkg::EV_OVERFLOW, 8'h00, 1'b1}},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'h3C}, 1'b1,
      '{csfw_pkg::EV_GRANTED, 8'h3C, 1'b1}},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'hC3}, 1'b0, NO_CHECK},
    // back to zero: block, wake, then flush more than one waiter
    '{1'b1, 16'h0000, NO_REQ, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'h81}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'h7E}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'h00}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_WAIT, 8'h42}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_CLOSE, 8'h00}, 1'b0, NO_CHECK},
    '{1'b0, 16'h0000, '{csfw_pkg::REQ_SIGNAL, 8'h00}, 1'b0, NO_CHECK}
  };

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  csfw_pkg::in_item_t  in_data           = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  csfw_pkg::out_item_t out_data;
  logic                cfg_wr_en         = 1'b0;
  logic [CFG_W-1:0]    cfg_initial_value = '0;

  // Predictor state
  logic signed [COUNT_W-1:0] sem_count = '0;
  logic [TID_W-1:0]          waiters[$];
  csfw_pkg::out_item_t       expected_events[$];

  // Idle pattern of the current phase, in percent (of requests for sender gaps, of cycles for stalls)
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned cycle_count     = 0;
  int unsigned mismatches      = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;

  counting_semaphore_fifo_waiters_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_initial_value (cfg_initial_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d results still expected", $time, expected_events.size());
    $display("Regression FAIL");
    $finish;
  end

  // Advance the predictor by one accepted request and queue the results it
  // should produce. The unused request code produces nothing.
  task automatic apply_request(input csfw_pkg::in_item_t it);
    csfw_pkg::out_item_t r;
    r.event_res  = csfw_pkg::EV_GRANTED;
    r.thread_out = it.thread_id;
    r.last       = 1'b1;
    case (it.req_type)
      csfw_pkg::REQ_WAIT: begin
        if (sem_count > 0) begin
          sem_count--;
          r.event_res = csfw_pkg::EV_GRANTED;
        end else if (waiters.size() >= QDEPTH || sem_count == COUNT_FLOOR) begin
          // refused: count and queue stay as they are
          r.event_res = csfw_pkg::EV_QUEUE_FULL;
        end else begin
          sem_count--;
          waiters.push_back(it.thread_id);
          r.event_res = csfw_pkg::EV_BLOCKED;
        end
        expected_events.push_back(r);
      end
      csfw_pkg::REQ_SIGNAL: begin
        r.thread_out = '0;
        if (sem_count == COUNT_CEIL) begin
          r.event_res = csfw_pkg::EV_OVERFLOW;
        end else begin
          sem_count++;
          if (sem_count <= 0 && waiters.size() > 0) begin
            r.event_res  = csfw_pkg::EV_WOKEN;
            r.thread_out = waiters.pop_front();
          end else begin
            r.event_res = csfw_pkg::EV_NO_WAITER;
          end
        end
        expected_events.push_back(r);
      end
      csfw_pkg::REQ_CLOSE: begin
        if (waiters.size() == 0) begin
          r.event_res  = csfw_pkg::EV_CLOSED_EMPTY;
          r.thread_out = '0;
          expected_events.push_back(r);
        end else begin
          // flush oldest first, count untouched
          while (waiters.size() > 0) begin
            r.event_res  = csfw_pkg::EV_WOKEN_FAIL;
            r.thread_out = waiters.pop_front();
            r.last       = (waiters.size() == 0);
            expected_events.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic csfw_pkg::in_item_t pack_request(input logic [REQ_W-1:0] req,
                                                      input logic [TID_W-1:0] tid);
    csfw_pkg::in_item_t it;
    it.req_type  = req;
    it.thread_id = tid;
    return it;
  endfunction

  // Mostly waits and signals so the queue fills and drains; closes now and
  // then, and a few unused codes as noise.
  function automatic csfw_pkg::in_item_t random_request();
    int unsigned pick;
    logic [REQ_W-1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req = csfw_pkg::REQ_WAIT;
    end else if (pick < 80) begin
      req = csfw_pkg::REQ_SIGNAL;
    end else if (pick < 92) begin
      req = csfw_pkg::REQ_CLOSE;
    end else begin
      req = csfw_pkg::REQ_NONE;
    end
    return pack_request(req, TID_W'($urandom_range(0, 255)));
  endfunction

  // Drive one request and hold it until the transfer. Drop valid for a random
  // gap first when the phase asks for sender idling; otherwise keep valid
  // high straight into the next request.
  task automatic send_request(input csfw_pkg::in_item_t it);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 5);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    apply_request(it);
    requests_sent++;
  endtask

  // Release the request channel, wait for every expected result, then give
  // the block time to finish a request that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Call only while the block is idle.
  task automatic load_initial_value(input logic [CFG_W-1:0] value);
    cfg_wr_en         <= 1'b1;
    cfg_initial_value <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sem_count = {1'b0, value};
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] start_count,
                           input int unsigned idle, input int unsigned stall);
    int unsigned counted;
    csfw_pkg::in_item_t it;
    counted = 0;
    settle();
    load_initial_value(start_count);
    idle_pct  = idle;
    stall_pct = stall;
    // ignored requests do not count toward the phase length
    while (counted < ITEMS_PER_PHASE) begin
      it = random_request();
      send_request(it);
      if (it.req_type != csfw_pkg::REQ_NONE) begin
        counted++;
      end
    end
  endtask

  // Result side: check each transfer against the oldest expectation, then
  // pick the stall for the next cycle.
  always @(posedge clk) begin
    csfw_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result event_res=%0d thread_out=%02h last=%0b",
                 $time, out_data.event_res, out_data.thread_out, out_data.last);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_res !== want.event_res) begin
          $display("%0t: event_res expected %0d got %0d",
                   $time, want.event_res, out_data.event_res);
          mismatches++;
        end
        if (out_data.thread_out !== want.thread_out) begin
          $display("%0t: thread_out expected %02h got %02h",
                   $time, want.thread_out, out_data.thread_out);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    dir_row_t row;
    int       p;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.is_cfg) begin
        settle();
        load_initial_value(row.cfg_val);
      end else begin
        send_request(row.req);
        // use the hand-written answer for single-result rows
        if (row.typed) begin
          expected_events[expected_events.size() - 1] = row.want;
        end
      end
    end

    // Fill the queue from count zero, get refused, wake the oldest, fill it
    // again, flush all sixteen, then block and wake once more.
    settle();
    load_initial_value('0);
    for (int i = 0; i < QDEPTH; i++) begin
      send_request(pack_request(csfw_pkg::REQ_WAIT, TID_W'(i * 7 + 1)));
    end
    send_request(pack_request(csfw_pkg::REQ_WAIT,   8'h11));
    send_request(pack_request(csfw_pkg::REQ_SIGNAL, 8'h00));
    send_request(pack_request(csfw_pkg::REQ_WAIT,   8'h22));
    send_request(pack_request(csfw_pkg::REQ_CLOSE,  8'h00));
    send_request(pack_request(csfw_pkg::REQ_WAIT,   8'h33));
    send_request(pack_request(csfw_pkg::REQ_SIGNAL, 8'h00));

    // Random phases: walk the idle patterns twice with varied start counts.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: run_phase(16'h0000, 0, 0);
        1: run_phase(16'hFFFF, 54, 0);
        2: run_phase(16'h0001, 0, 54);
        3: run_phase(16'h0002, 29, 29);
        4: run_phase(CFG_W'($urandom_range(0, 3)), 0, 0);
        5: run_phase(CFG_W'($urandom), 54, 0);
        6: run_phase(16'h0003, 0, 54);
        default: run_phase(16'h0000, 29, 29);
      endcase
    end

    settle();
    idle_pct  = 0;
    stall_pct = 0;

    $display("Sent %0d requests and checked %0d results in %0d cycles.",
             requests_sent, results_checked, cycle_count);
    $display("Covered the count ceiling, negative counts, a full queue, flushes and idle patterns.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: counting_semaphore_fifo_waiters_core.f
+incdir+design
design/csfw_pkg.sv
design/csfw_ram.sv
design/csfw_dp.sv
design/csfw_ctrl.sv
design/counting_semaphore_fifo_waiters_core.sv
sim/testbench.sv
